[design/rsi_pkg.sv]
// Package for the ray against sphere intersection block.
// Holds default widths, the multiplier limb width and configuration register indexes.
// No dependencies.
package rsi_pkg;

  // Default coordinate format: signed Q16.16
  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;

  // Limb width used to split wide products into narrow partial products
  localparam int LIMB_WIDTH = 24;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_CENTER_X = 2'd0,
    REG_CENTER_Y = 2'd1,
    REG_CENTER_Z = 2'd2,
    REG_RADIUS   = 2'd3
  } reg_idx_e;

endpackage

[design/ray_sphere_intersect.sv]
// Ray against sphere intersection (nearer root only), fully pipelined.
// Depends on rsi_pkg for default widths, limb width and register indexes.
//
// One ray word is accepted every cycle unless in_stall_o is raised. SW =
// 2*COORD_WIDTH + 4 + FRAC_BITS is the number of root bits and TW =
// COORD_WIDTH - 1 the number of distance bits (84 and 31 at the default
// Q16.16 format). The square root resolves one root bit per stage and the
// divider resolves one quotient bit per stage.
// All stages advance together; when the
// output word is held by out_stall_i the whole pipeline holds and in_stall_o
// is raised. Configuration registers may be written only while the pipeline
// is empty; a radius write keeps the low COORD_WIDTH-1 data bits.
module ray_sphere_intersect
  import rsi_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [COORD_WIDTH-1:0]        cfg_data_i,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [COORD_WIDTH-1:0] origin_x_i,
  input  logic signed [COORD_WIDTH-1:0] origin_y_i,
  input  logic signed [COORD_WIDTH-1:0] origin_z_i,
  input  logic signed [COORD_WIDTH-1:0] dir_x_i,
  input  logic signed [COORD_WIDTH-1:0] dir_y_i,
  input  logic signed [COORD_WIDTH-1:0] dir_z_i,
  input  logic [COORD_WIDTH-2:0]        best_t_i,
  // output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          is_hit_o,
  output logic [COORD_WIDTH-2:0]        new_t_o,
  output logic signed [COORD_WIDTH-1:0] hit_x_o,
  output logic signed [COORD_WIDTH-1:0] hit_y_o,
  output logic signed [COORD_WIDTH-1:0] hit_z_o
);

  localparam int W   = COORD_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int RW  = W - 1;
  localparam int TW  = W - 1;
  localparam int LW  = LIMB_WIDTH;
  localparam int VW  = W + 1;
  localparam int AW  = 2 * W + 2;
  localparam int BW  = 2 * W + 3;
  localparam int CW  = 2 * W + 4;
  localparam int NBL = (BW + LW - 1) / LW;
  localparam int NAL = (AW + LW - 1) / LW;
  localparam int NCL = (CW + LW - 1) / LW;
  localparam int PW  = 2 * BW;
  localparam int QW  = PW + 1;
  localparam int XW0 = QW + 2 * F;
  localparam int XE  = XW0 + (XW0 % 2);
  localparam int SW  = XE / 2;
  localparam int NW  = SW + 2;
  localparam int DW  = AW + TW;
  localparam int KW  = (NW > DW) ? NW : DW;
  localparam int PRW = W + TW + 1;
  localparam int HW  = PRW + 1;

  // stage numbers
  localparam int ST_SUM = 2;
  localparam int ST_MAG = 3;
  localparam int ST_Q   = 6;
  localparam int ST_N   = 7 + SW;
  localparam int ST_T   = ST_N + TW + 1;
  localparam int ST_P   = ST_T + 1;
  localparam int LAST   = ST_P + 1;

  localparam logic [RW-1:0] RAD_RST = RW'(64'd10 << F);

  typedef struct packed {
    logic                ok;
    logic                az;
    logic                cn;
    logic [2:0][W-1:0]   o;
    logic [2:0][W-1:0]   d;
    logic [TW-1:0]       best;
    logic [AW-1:0]       a;
    logic [BW-1:0]       b;
  } side_t;

  // configuration registers
  logic [W-1:0]  cen_q [3];
  logic [RW-1:0] rad_q;

  // pipeline control
  logic          adv;
  logic [LAST:0] vld_q;
  side_t         sd_q [LAST+1];
  side_t         sd_d [LAST+1];

  // stage data
  logic signed [VW-1:0]    v_q  [3];
  logic signed [2*W-1:0]   dd_q [3];
  logic signed [2*W:0]     vd_q [3];
  logic signed [2*W+1:0]   vv_q [3];
  logic [2*RW-1:0]         rr_q;
  logic [AW-1:0]           a_d;
  logic [BW-1:0]           b_d;
  logic [CW-1:0]           c_d, c_q;
  logic [BW-1:0]           bm_q;
  logic [CW-1:0]           cm_q;
  logic [NBL*LW-1:0]       bpad;
  logic [NAL*LW-1:0]       apad;
  logic [NCL*LW-1:0]       cpad;
  logic [NBL-1:0][NBL-1:0][2*LW-1:0] ppbb_q;
  logic [NAL-1:0][NCL-1:0][2*LW-1:0] ppac_q;
  logic [PW-1:0]           bb_d, ac_d, bb_q, ac_q;
  logic [QW-1:0]           q_d;
  logic                    qneg;
  logic [XE-1:0]           sx_q [SW+1];
  logic [SW-1:0]           rt_q [SW+1];
  logic [SW+1:0]           rm_q [SW+1];
  logic [XE-1:0]           sx_d [SW+1];
  logic [SW-1:0]           rt_d [SW+1];
  logic [SW+1:0]           rm_d [SW+1];
  logic signed [NW-1:0]    n_d;
  logic                    n_ok;
  logic [DW-1:0]           dr_q [TW+1];
  logic [TW-1:0]           dq_q [TW+1];
  logic [DW-1:0]           dr_d [TW+1];
  logic [TW-1:0]           dq_d [TW+1];
  logic [TW-1:0]           t_q;
  logic [TW-1:0]           tp_q;
  logic signed [PRW-1:0]   pr_q [3];
  logic signed [HW-1:0]    hs   [3];
  logic signed [W-1:0]     hsat [3];
  logic                    hit_q;
  logic [TW-1:0]           newt_q;
  logic signed [W-1:0]     hx_q [3];

  // write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cen_q[0] <= '0;
      cen_q[1] <= '0;
      cen_q[2] <= '0;
      rad_q    <= RAD_RST;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_CENTER_X: cen_q[0] <= cfg_data_i;
        REG_CENTER_Y: cen_q[1] <= cfg_data_i;
        REG_CENTER_Z: cen_q[2] <= cfg_data_i;
        REG_RADIUS:   rad_q    <= cfg_data_i[RW-1:0];
        default:      rad_q    <= rad_q;
      endcase
    end
  end

  // advance the whole pipeline unless the output word is held
  assign adv        = !(vld_q[LAST] && out_stall_i);
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[LAST-1:0], in_valid_i};
    end
  end

  // sums of products and the padding of |B|, A and |C| into limbs
  always_comb begin
    a_d = AW'($unsigned(dd_q[0])) + AW'($unsigned(dd_q[1])) + AW'($unsigned(dd_q[2]));
    b_d = BW'(vd_q[0]) + BW'(vd_q[1]) + BW'(vd_q[2]);
    c_d = CW'(vv_q[0]) + CW'(vv_q[1]) + CW'(vv_q[2]) - CW'(rr_q);
    bpad = (NBL*LW)'(bm_q);
    apad = (NAL*LW)'(sd_q[ST_MAG].a);
    cpad = (NCL*LW)'(cm_q);
  end

  // gather partial products of B*B and A*|C|
  always_comb begin
    bb_d = '0;
    ac_d = '0;
    for (int i = 0; i < NBL; i++) begin
      for (int j = 0; j < NBL; j++) begin
        bb_d = bb_d + (PW'(ppbb_q[i][j]) << (LW * (i + j)));
      end
    end
    for (int i = 0; i < NAL; i++) begin
      for (int j = 0; j < NCL; j++) begin
        ac_d = ac_d + (PW'(ppac_q[i][j]) << (LW * (i + j)));
      end
    end
  end

  // reduced discriminant
  always_comb begin
    q_d  = sd_q[ST_Q-1].cn ? (QW'(bb_q) + QW'(ac_q)) : (QW'(bb_q) - QW'(ac_q));
    qneg = !sd_q[ST_Q-1].cn && (bb_q < ac_q);
  end

  // one root bit per square root stage
  always_comb begin
    sx_d[0] = XE'(q_d) << (2 * F);
    rt_d[0] = '0;
    rm_d[0] = '0;
    for (int k = 0; k < SW; k++) begin
      logic [SW+1:0] rem_t;
      logic [SW+1:0] trial;
      rem_t = {rm_q[k][SW-1:0], sx_q[k][XE-1:XE-2]};
      trial = {rt_q[k], 2'b01};
      sx_d[k+1] = sx_q[k] << 2;
      if (rem_t >= trial) begin
        rm_d[k+1] = rem_t - trial;
        rt_d[k+1] = {rt_q[k][SW-2:0], 1'b1};
      end else begin
        rm_d[k+1] = rem_t;
        rt_d[k+1] = {rt_q[k][SW-2:0], 1'b0};
      end
    end
  end

  // numerator of the nearer root and its range check
  always_comb begin
    n_d  = -(NW'($signed(sd_q[ST_N-1].b)) <<< F) - $signed(NW'(rt_q[SW]));
    n_ok = !n_d[NW-1] && (n_d != '0) &&
           (KW'($unsigned(n_d)) < (KW'(sd_q[ST_N-1].a) << TW));
  end

  // one quotient bit per divider stage
  always_comb begin
    dr_d[0] = DW'($unsigned(n_d));
    dq_d[0] = '0;
    for (int k = 0; k < TW; k++) begin
      logic [DW-1:0] dv;
      dv = DW'(sd_q[ST_N+k].a) << (TW - 1 - k);
      if (dr_q[k] >= dv) begin
        dr_d[k+1] = dr_q[k] - dv;
        dq_d[k+1] = dq_q[k] | (TW'(1) << (TW - 1 - k));
      end else begin
        dr_d[k+1] = dr_q[k];
        dq_d[k+1] = dq_q[k];
      end
    end
  end

  // hit point per axis with saturation
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      hs[k] = HW'($signed(sd_q[LAST-1].o[k])) + HW'(pr_q[k] >>> F);
      if (hs[k][HW-1:W-1] != {(HW-W+1){hs[k][W-1]}}) begin
        hsat[k] = hs[k][HW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end else begin
        hsat[k] = hs[k][W-1:0];
      end
    end
  end

  // sideband: pass along, update flags at the deciding stages
  always_comb begin
    sd_d[0]      = '0;
    sd_d[0].o[0] = origin_x_i;
    sd_d[0].o[1] = origin_y_i;
    sd_d[0].o[2] = origin_z_i;
    sd_d[0].d[0] = dir_x_i;
    sd_d[0].d[1] = dir_y_i;
    sd_d[0].d[2] = dir_z_i;
    sd_d[0].best = best_t_i;
    for (int k = 1; k <= LAST; k++) begin
      sd_d[k] = sd_q[k-1];
    end
    sd_d[ST_SUM].a  = a_d;
    sd_d[ST_SUM].b  = b_d;
    sd_d[ST_MAG].az = (sd_q[ST_MAG-1].a == '0);
    sd_d[ST_MAG].cn = c_q[CW-1];
    sd_d[ST_Q].ok   = !sd_q[ST_Q-1].az && !qneg;
    sd_d[ST_N].ok   = sd_q[ST_N-1].ok && n_ok;
    sd_d[ST_T].ok   = sd_q[ST_T-1].ok && (dq_q[TW] != '0) &&
                      (dq_q[TW] < sd_q[ST_T-1].best);
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k <= LAST; k++) begin
        sd_q[k] <= sd_d[k];
      end
      // offset from centre
      for (int k = 0; k < 3; k++) begin
        v_q[k] <= $signed(VW'($signed(sd_d[0].o[k]))) - $signed(VW'($signed(cen_q[k])));
      end
      // squares and dot products
      for (int k = 0; k < 3; k++) begin
        dd_q[k] <= $signed(sd_q[0].d[k]) * $signed(sd_q[0].d[k]);
        vd_q[k] <= v_q[k] * $signed(sd_q[0].d[k]);
        vv_q[k] <= v_q[k] * v_q[k];
      end
      rr_q <= rad_q * rad_q;
      c_q  <= c_d;
      // magnitudes
      bm_q <= sd_q[ST_MAG-1].b[BW-1] ? -sd_q[ST_MAG-1].b : sd_q[ST_MAG-1].b;
      cm_q <= c_q[CW-1] ? -c_q : c_q;
      // limb products
      for (int i = 0; i < NBL; i++) begin
        for (int j = 0; j < NBL; j++) begin
          ppbb_q[i][j] <= bpad[i*LW +: LW] * bpad[j*LW +: LW];
        end
      end
      for (int i = 0; i < NAL; i++) begin
        for (int j = 0; j < NCL; j++) begin
          ppac_q[i][j] <= apad[i*LW +: LW] * cpad[j*LW +: LW];
        end
      end
      bb_q <= bb_d;
      ac_q <= ac_d;
      // square root and divider stages
      for (int k = 0; k <= SW; k++) begin
        sx_q[k] <= sx_d[k];
        rt_q[k] <= rt_d[k];
        rm_q[k] <= rm_d[k];
      end
      for (int k = 0; k <= TW; k++) begin
        dr_q[k] <= dr_d[k];
        dq_q[k] <= dq_d[k];
      end
      t_q  <= dq_q[TW];
      tp_q <= t_q;
      // direction times distance
      for (int k = 0; k < 3; k++) begin
        pr_q[k] <= $signed(sd_q[ST_P-1].d[k]) * $signed({1'b0, t_q});
      end
      // result word
      hit_q  <= sd_q[LAST-1].ok;
      newt_q <= sd_q[LAST-1].ok ? tp_q : sd_q[LAST-1].best;
      for (int k = 0; k < 3; k++) begin
        hx_q[k] <= sd_q[LAST-1].ok ? hsat[k] : '0;
      end
    end
  end

  // the distance register moves with the result stage
  assign out_valid_o = vld_q[LAST];
  assign is_hit_o    = hit_q;
  assign new_t_o     = newt_q;
  assign hit_x_o     = hx_q[0];
  assign hit_y_o     = hx_q[1];
  assign hit_z_o     = hx_q[2];

endmodule
